// File: design/rsa_pkg.sv
// ----------------------------------------------------------------------------
// RSA package
// Shared widths, codes and controller-datapath command/status types.
// ----------------------------------------------------------------------------
package rsa_pkg;

   localparam int PRIME_BITS   = 21;
   localparam int MODULUS_BITS = 42;
   localparam int NB           = MODULUS_BITS;
   localparam int CNT_BITS     = $clog2(NB + 1);

   localparam logic [PRIME_BITS-1:0] PRIME_P_RESET = PRIME_BITS'(61);
   localparam logic [PRIME_BITS-1:0] PRIME_Q_RESET = PRIME_BITS'(53);

   localparam logic [0:0] CSR_PRIME_P = 1'd0;
   localparam logic [0:0] CSR_PRIME_Q = 1'd1;

   localparam logic [1:0] OP_DERIVE  = 2'd0;
   localparam logic [1:0] OP_ENCRYPT = 2'd1;
   localparam logic [1:0] OP_DECRYPT = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_KEYS  = 2'd1;
   localparam logic [1:0] ST_BAD_KEYS = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_PHI_MUL,
      S_N_MUL,
      S_E_CHECK,
      S_GCD_INIT,
      S_GCD_DIV,
      S_GCD_STEP,
      S_INV_INIT,
      S_INV_DIV,
      S_INV_QMUL,
      S_INV_STEP,
      S_KEY_DONE,
      S_EXP_RED,
      S_EXP_INIT,
      S_EXP_BIT,
      S_EXP_MUL_ACC,
      S_EXP_MUL_SQR,
      S_EXP_SHIFT,
      S_RESP
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_START,
      CMD_LOAD_PHI,
      CMD_LOAD_N,
      CMD_KEY_FAIL,
      CMD_E_NEXT,
      CMD_GCD_INIT,
      CMD_DIV_START_GCD,
      CMD_GCD_STEP,
      CMD_INV_INIT,
      CMD_DIV_START_INV,
      CMD_MUL_START_Q,
      CMD_INV_STEP,
      CMD_KEY_DONE,
      CMD_RED_START,
      CMD_EXP_INIT,
      CMD_MUL_START_ACC,
      CMD_MUL_START_SQR,
      CMD_EXP_SHIFT,
      CMD_RESULT_ZERO
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [1:0] status;
   } ctrl_type;

   typedef struct packed {
      logic       unit_busy;
      logic       primes_bad;
      logic       e_ge_phi;
      logic       gcd_zero;
      logic       gcd_one;
      logic       inv_zero;
      logic       exp_zero;
      logic       exp_bit;
      logic       keys_ready;
   } stat_type;

endpackage

// File: design/rsa_datapath.sv
// ----------------------------------------------------------------------------
// RSA datapath
// Key and working registers with a shared bit-serial modular multiplier and
// a restoring divider, both stepped one bit per cycle.
// ----------------------------------------------------------------------------
module rsa_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [rsa_pkg::PRIME_BITS-1:0]  prime_p,
   input  logic [rsa_pkg::PRIME_BITS-1:0]  prime_q,
   input  logic [rsa_pkg::NB-1:0]          msg,
   input  logic [1:0]                      op,
   input  rsa_pkg::ctrl_type               ctrl,
   output rsa_pkg::stat_type               stat,
   output logic [rsa_pkg::NB-1:0]          result_value,
   output logic [rsa_pkg::NB-1:0]          public_exponent,
   output logic [rsa_pkg::NB-1:0]          private_exponent,
   output logic [rsa_pkg::NB-1:0]          modulus_out
);
   import rsa_pkg::*;

   logic [NB-1:0] mod_ff, mod_in, phi_ff, phi_in, e_ff, e_in, d_ff, d_in;
   logic          ready_ff, ready_in;
   logic [NB-1:0] a_ff, a_in, b_ff, b_in, s0_ff, s0_in, s1_ff, s1_in;
   logic [NB-1:0] acc_ff, acc_in, base_ff, base_in, ex_ff, ex_in;
   logic [NB-1:0] res_ff, res_in;
   logic [PRIME_BITS-1:0] pm_ff, pm_in, qm_ff, qm_in;

   // shared multiplier: mx * my mod mm, LSB first on my
   logic          mul_busy_ff, mul_busy_in;
   logic [NB-1:0] mx_ff, mx_in, my_ff, my_in, mm_ff, mm_in, mp_ff, mp_in;

   // shared divider: dn / dd
   logic          div_busy_ff, div_busy_in;
   logic [NB-1:0] dn_ff, dn_in, dd_ff, dd_in, dq_ff, dq_in, dr_ff, dr_in;
   logic [CNT_BITS-1:0] dc_ff, dc_in;

   logic [NB:0]   t_sum, t_dbl, r_sh;
   logic [NB-1:0] p_add, x_dbl;
   logic [2*PRIME_BITS-1:0] pq;

   always_comb begin
      t_sum = {1'b0, mp_ff} + {1'b0, mx_ff};
      p_add = (t_sum >= {1'b0, mm_ff}) ? NB'(t_sum - {1'b0, mm_ff}) : NB'(t_sum);
      t_dbl = {mx_ff, 1'b0};
      x_dbl = (t_dbl >= {1'b0, mm_ff}) ? NB'(t_dbl - {1'b0, mm_ff}) : NB'(t_dbl);
      r_sh  = {dr_ff, dn_ff[NB-1]};
      pq    = pm_ff * qm_ff;
   end

   always_comb begin
      mod_in = mod_ff; phi_in = phi_ff; e_in = e_ff; d_in = d_ff;
      ready_in = ready_ff;
      a_in = a_ff; b_in = b_ff; s0_in = s0_ff; s1_in = s1_ff;
      acc_in = acc_ff; base_in = base_ff; ex_in = ex_ff; res_in = res_ff;
      pm_in = pm_ff; qm_in = qm_ff;
      mul_busy_in = mul_busy_ff; mx_in = mx_ff; my_in = my_ff;
      mm_in = mm_ff; mp_in = mp_ff;
      div_busy_in = div_busy_ff; dn_in = dn_ff; dd_in = dd_ff;
      dq_in = dq_ff; dr_in = dr_ff; dc_in = dc_ff;

      if (mul_busy_ff) begin
         if (my_ff == '0) begin
            mul_busy_in = 1'b0;
         end else begin
            if (my_ff[0]) mp_in = p_add;
            mx_in = x_dbl;
            my_in = my_ff >> 1;
         end
      end
      if (div_busy_ff) begin
         if (dc_ff == '0) begin
            div_busy_in = 1'b0;
         end else begin
            dn_in = dn_ff << 1;
            if (r_sh >= {1'b0, dd_ff}) begin
               dr_in = NB'(r_sh - {1'b0, dd_ff});
               dq_in = {dq_ff[NB-2:0], 1'b1};
            end else begin
               dr_in = NB'(r_sh);
               dq_in = {dq_ff[NB-2:0], 1'b0};
            end
            dc_in = dc_ff - 1'b1;
         end
      end

      case (ctrl.cmd)
         CMD_START: begin
            res_in = '0;
            if (op == OP_DERIVE) begin
               mod_in = '0; phi_in = '0; e_in = '0; d_in = '0; ready_in = 1'b0;
               pm_in = prime_p - 1'b1; qm_in = prime_q - 1'b1;
            end
         end
         CMD_LOAD_PHI: begin
            phi_in = NB'(pq);
            pm_in = prime_p; qm_in = prime_q;
            e_in = NB'(2);
         end
         CMD_LOAD_N:   mod_in = NB'(pq);
         CMD_KEY_FAIL: begin
            mod_in = '0; e_in = '0;
         end
         CMD_E_NEXT:   e_in = e_ff + 1'b1;
         CMD_GCD_INIT: begin
            a_in = e_ff; b_in = phi_ff;
         end
         CMD_DIV_START_GCD, CMD_DIV_START_INV: begin
            div_busy_in = 1'b1; dn_in = a_ff; dd_in = b_ff;
            dq_in = '0; dr_in = '0; dc_in = CNT_BITS'(NB);
         end
         CMD_GCD_STEP: begin
            a_in = b_ff; b_in = dr_ff;
         end
         CMD_INV_INIT: begin
            a_in = e_ff; b_in = phi_ff; s0_in = NB'(1); s1_in = '0;
         end
         CMD_MUL_START_Q: begin
            mul_busy_in = 1'b1; mx_in = s1_ff; my_in = dq_ff;
            mm_in = phi_ff; mp_in = '0;
         end
         CMD_INV_STEP: begin
            a_in = b_ff; b_in = dr_ff; s0_in = s1_ff;
            s1_in = (s0_ff >= mp_ff) ? s0_ff - mp_ff : s0_ff + (phi_ff - mp_ff);
         end
         CMD_KEY_DONE: begin
            d_in = s0_ff; ready_in = 1'b1;
         end
         CMD_RED_START: begin
            div_busy_in = 1'b1; dn_in = msg; dd_in = mod_ff;
            dq_in = '0; dr_in = '0; dc_in = CNT_BITS'(NB);
         end
         CMD_EXP_INIT: begin
            base_in = dr_ff;
            acc_in = (mod_ff == NB'(1)) ? '0 : NB'(1);
            ex_in = (op == OP_ENCRYPT) ? e_ff : d_ff;
         end
         CMD_MUL_START_ACC: begin
            mul_busy_in = 1'b1; mx_in = base_ff; my_in = acc_ff;
            mm_in = mod_ff; mp_in = '0;
         end
         CMD_MUL_START_SQR: begin
            if (ex_ff[0]) acc_in = mp_ff;
            mul_busy_in = 1'b1; mx_in = base_ff; my_in = base_ff;
            mm_in = mod_ff; mp_in = '0;
         end
         CMD_EXP_SHIFT: begin
            base_in = mp_ff; ex_in = ex_ff >> 1;
         end
         CMD_RESULT_ZERO: res_in = acc_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= '0; phi_ff <= '0; e_ff <= '0; d_ff <= '0; ready_ff <= 1'b0;
         mul_busy_ff <= 1'b0; div_busy_ff <= 1'b0;
      end else begin
         mod_ff <= mod_in; phi_ff <= phi_in; e_ff <= e_in; d_ff <= d_in;
         ready_ff <= ready_in;
         mul_busy_ff <= mul_busy_in; div_busy_ff <= div_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; s0_ff <= s0_in; s1_ff <= s1_in;
      acc_ff <= acc_in; base_ff <= base_in; ex_ff <= ex_in; res_ff <= res_in;
      pm_ff <= pm_in; qm_ff <= qm_in;
      mx_ff <= mx_in; my_ff <= my_in; mm_ff <= mm_in; mp_ff <= mp_in;
      dn_ff <= dn_in; dd_ff <= dd_in; dq_ff <= dq_in; dr_ff <= dr_in; dc_ff <= dc_in;
   end

   always_comb begin
      stat.unit_busy  = mul_busy_ff | div_busy_ff;
      stat.primes_bad = (prime_p == prime_q) || (prime_p < PRIME_BITS'(2)) ||
                        (prime_q < PRIME_BITS'(2));
      stat.e_ge_phi   = e_ff >= phi_ff;
      stat.gcd_zero   = b_ff == '0;
      stat.gcd_one    = a_ff == NB'(1);
      stat.inv_zero   = b_ff == '0;
      stat.exp_zero   = ex_ff == '0;
      stat.exp_bit    = ex_ff[0];
      stat.keys_ready = ready_ff;
   end

   assign result_value     = res_ff;
   assign public_exponent  = e_ff;
   assign private_exponent = d_ff;
   assign modulus_out      = mod_ff;

endmodule

// File: design/rsa_ctrl.sv
// ----------------------------------------------------------------------------
// RSA controller
// Sequences key derivation, operand reduction and square-and-multiply.
// ----------------------------------------------------------------------------
module rsa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        op,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        status,
   output rsa_pkg::ctrl_type ctrl,
   input  rsa_pkg::stat_type stat
);
   import rsa_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      status_in   = status_ff;
      ctrl.cmd    = CMD_NONE;
      ctrl.status = status_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.cmd = CMD_START;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (op == OP_DERIVE) begin
               if (stat.primes_bad) begin
                  status_in = ST_BAD_KEYS;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_PHI_MUL;
               end
            end else if (!stat.keys_ready) begin
               status_in = ST_NO_KEYS;
               state_in  = S_RESP;
            end else if (op == OP_ENCRYPT || op == OP_DECRYPT) begin
               status_in = ST_OK;
               ctrl.cmd  = CMD_RED_START;
               state_in  = S_EXP_RED;
            end else begin
               status_in = ST_OK;
               state_in  = S_RESP;
            end
         end
         S_PHI_MUL: begin
            ctrl.cmd = CMD_LOAD_PHI;
            state_in = S_N_MUL;
         end
         S_N_MUL: begin
            ctrl.cmd = CMD_LOAD_N;
            state_in = S_E_CHECK;
         end
         S_E_CHECK: begin
            if (stat.e_ge_phi) begin
               ctrl.cmd  = CMD_KEY_FAIL;
               status_in = ST_BAD_KEYS;
               state_in  = S_RESP;
            end else begin
               ctrl.cmd = CMD_GCD_INIT;
               state_in = S_GCD_INIT;
            end
         end
         S_GCD_INIT: begin
            if (stat.gcd_zero) begin
               if (stat.gcd_one) begin
                  ctrl.cmd = CMD_INV_INIT;
                  state_in = S_INV_INIT;
               end else begin
                  ctrl.cmd = CMD_E_NEXT;
                  state_in = S_E_CHECK;
               end
            end else begin
               ctrl.cmd = CMD_DIV_START_GCD;
               state_in = S_GCD_DIV;
            end
         end
         S_GCD_DIV: begin
            if (!stat.unit_busy) begin
               ctrl.cmd = CMD_GCD_STEP;
               state_in = S_GCD_INIT;
            end
         end
         S_INV_INIT: begin
            if (stat.inv_zero) begin
               ctrl.cmd  = CMD_KEY_DONE;
               status_in = ST_OK;
               state_in  = S_RESP;
            end else begin
               ctrl.cmd = CMD_DIV_START_INV;
               state_in = S_INV_DIV;
            end
         end
         S_INV_DIV: begin
            if (!stat.unit_busy) begin
               ctrl.cmd = CMD_MUL_START_Q;
               state_in = S_INV_QMUL;
            end
         end
         S_INV_QMUL: begin
            if (!stat.unit_busy) begin
               ctrl.cmd = CMD_INV_STEP;
               state_in = S_INV_INIT;
            end
         end
         S_EXP_RED: begin
            if (!stat.unit_busy) begin
               ctrl.cmd = CMD_EXP_INIT;
               state_in = S_EXP_BIT;
            end
         end
         S_EXP_BIT: begin
            if (stat.exp_zero) begin
               ctrl.cmd = CMD_RESULT_ZERO;
               state_in = S_RESP;
            end else begin
               ctrl.cmd = CMD_MUL_START_ACC;
               state_in = S_EXP_MUL_ACC;
            end
         end
         S_EXP_MUL_ACC: begin
            if (!stat.unit_busy) begin
               ctrl.cmd = CMD_MUL_START_SQR;
               state_in = S_EXP_MUL_SQR;
            end
         end
         S_EXP_MUL_SQR: begin
            if (!stat.unit_busy) begin
               ctrl.cmd = CMD_EXP_SHIFT;
               state_in = S_EXP_BIT;
            end
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign status = status_ff;

endmodule

// File: design/rsa_key_derive_and_modexp.sv
// ----------------------------------------------------------------------------
// RSA key derivation and modular exponentiation
// Derives textbook RSA keys from two configured primes and encrypts or
// decrypts values by square-and-multiply.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_op, req_message_value
//   rsp      out        rsp_valid/rsp_ready    result, exponents, modulus, status
//   csr      in         csr_write_enable       csr_index, csr_write_data
//
// One request is in flight at a time. Encrypt and decrypt run two modular
// multiplies per exponent bit, each stepping one multiplier bit a cycle,
// after an initial reduction of the message. Derive runs one division per
// Euclid step, plus a multiply per step of the inverse, so its length
// follows the primes.
// Reset is synchronous and clears the keys; a stalled response holds the
// block until it is taken.
module rsa_key_derive_and_modexp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_op,
   input  logic [rsa_pkg::NB-1:0]         req_message_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rsa_pkg::NB-1:0]         rsp_result_value,
   output logic [rsa_pkg::NB-1:0]         rsp_public_exponent,
   output logic [rsa_pkg::NB-1:0]         rsp_private_exponent,
   output logic [rsa_pkg::NB-1:0]         rsp_modulus_out,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_write_enable,
   input  logic [0:0]                     csr_index,
   input  logic [rsa_pkg::PRIME_BITS-1:0] csr_write_data
);
   import rsa_pkg::*;

   logic [PRIME_BITS-1:0] prime_p_ff, prime_q_ff;
   logic [1:0]            op_ff;
   logic [1:0]            op_dp;
   logic [NB-1:0]         msg_ff;
   ctrl_type              ctrl;
   stat_type              stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_p_ff <= PRIME_P_RESET;
         prime_q_ff <= PRIME_Q_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_PRIME_P) prime_p_ff <= csr_write_data;
         if (csr_index == CSR_PRIME_Q) prime_q_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff  <= req_op;
         msg_ff <= req_message_value;
      end
   end

   // The start command is issued in the accepting cycle, before op_ff holds the new code.
   assign op_dp = (req_valid && req_ready) ? req_op : op_ff;

   rsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .op        (op_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (rsp_status),
      .ctrl      (ctrl),
      .stat      (stat)
   );

   rsa_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .prime_p          (prime_p_ff),
      .prime_q          (prime_q_ff),
      .msg              (msg_ff),
      .op               (op_dp),
      .ctrl             (ctrl),
      .stat             (stat),
      .result_value     (rsp_result_value),
      .public_exponent  (rsp_public_exponent),
      .private_exponent (rsp_private_exponent),
      .modulus_out      (rsp_modulus_out)
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request accepted while busy");
   a_ok_has_keys: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OK && rsp_modulus_out != '0) |->
      rsp_public_exponent != '0) else $error("modulus without exponent");
   a_bad_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_BAD_KEYS) |-> rsp_modulus_out == '0)
      else $error("failed derive left a modulus");

endmodule
